/* rtl/owbm_pkg.sv */
// owbm_pkg: shared widths, request codes, register indexes and the
// configuration bundle for the 1-Wire bus master.
// No dependencies; used by every other file of the block.
package owbm_pkg;

    // field widths
    localparam int CFG_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int REQ_W      = 3;
    localparam int BYTE_W     = 8;
    localparam int BIT_CNT_W  = 4;

    // bits in one byte transfer
    localparam logic [BIT_CNT_W-1:0] BITS_PER_BYTE = 4'd8;

    // request codes
    localparam logic [REQ_W-1:0] REQ_TICK   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_RESET  = 3'd1;
    localparam logic [REQ_W-1:0] REQ_WBIT   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_WBYTE  = 3'd3;
    localparam logic [REQ_W-1:0] REQ_RBIT   = 3'd4;
    localparam logic [REQ_W-1:0] REQ_RBYTE  = 3'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_RESET_LOW     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESENCE_SMP  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RESET_REC     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_LOW      = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_HOLD    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_WRITE_REC     = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_READ_SMP      = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_READ_REC      = 3'd7;

    // reset values of the timing registers, in ticks
    localparam logic [CFG_W-1:0] DEF_RESET_LOW    = 10'd480;
    localparam logic [CFG_W-1:0] DEF_PRESENCE_SMP = 10'd100;
    localparam logic [CFG_W-1:0] DEF_RESET_REC    = 10'd380;
    localparam logic [CFG_W-1:0] DEF_SLOT_LOW     = 10'd2;
    localparam logic [CFG_W-1:0] DEF_WRITE_HOLD   = 10'd58;
    localparam logic [CFG_W-1:0] DEF_WRITE_REC    = 10'd1;
    localparam logic [CFG_W-1:0] DEF_READ_SMP     = 10'd10;
    localparam logic [CFG_W-1:0] DEF_READ_REC     = 10'd49;

    // timing register bundle
    typedef struct packed {
        logic [CFG_W-1:0] reset_low;
        logic [CFG_W-1:0] presence_smp;
        logic [CFG_W-1:0] reset_rec;
        logic [CFG_W-1:0] slot_low;
        logic [CFG_W-1:0] write_hold;
        logic [CFG_W-1:0] write_rec;
        logic [CFG_W-1:0] read_smp;
        logic [CFG_W-1:0] read_rec;
    } owbm_cfg_t;

    // a zero duration counts as one tick
    function automatic logic [CFG_W-1:0] dur(input logic [CFG_W-1:0] v);
        dur = (v == '0) ? CFG_W'(1) : v;
    endfunction

endpackage

/* rtl/owbm_cfg_regs.sv */
// owbm_cfg_regs: the eight slot timing registers behind the write port.
// Depends on owbm_pkg.
module owbm_cfg_regs (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_we,
    input  logic [owbm_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [owbm_pkg::CFG_W-1:0]      cfg_data,
    output owbm_pkg::owbm_cfg_t             cfg
);
    import owbm_pkg::*;

    owbm_cfg_t cfg_reg;

    // register file with reset defaults
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.reset_low    <= DEF_RESET_LOW;
            cfg_reg.presence_smp <= DEF_PRESENCE_SMP;
            cfg_reg.reset_rec    <= DEF_RESET_REC;
            cfg_reg.slot_low     <= DEF_SLOT_LOW;
            cfg_reg.write_hold   <= DEF_WRITE_HOLD;
            cfg_reg.write_rec    <= DEF_WRITE_REC;
            cfg_reg.read_smp     <= DEF_READ_SMP;
            cfg_reg.read_rec     <= DEF_READ_REC;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_RESET_LOW:    cfg_reg.reset_low    <= cfg_data;
                REG_PRESENCE_SMP: cfg_reg.presence_smp <= cfg_data;
                REG_RESET_REC:    cfg_reg.reset_rec    <= cfg_data;
                REG_SLOT_LOW:     cfg_reg.slot_low     <= cfg_data;
                REG_WRITE_HOLD:   cfg_reg.write_hold   <= cfg_data;
                REG_WRITE_REC:    cfg_reg.write_rec    <= cfg_data;
                REG_READ_SMP:     cfg_reg.read_smp     <= cfg_data;
                REG_READ_REC:     cfg_reg.read_rec     <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/owbm_core.sv */
// owbm_core: slot sequencer, one tick per accepted beat, with the result
// register and its valid flag.
// Depends on owbm_pkg and the timing bundle from owbm_cfg_regs.
module owbm_core (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  owbm_pkg::owbm_cfg_t           cfg,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [owbm_pkg::REQ_W-1:0]    s_req_type,
    input  logic [owbm_pkg::BYTE_W-1:0]   s_write_data,
    input  logic                          s_line_level,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_drive_low,
    output logic                          m_busy_res,
    output logic                          m_done_res,
    output logic                          m_presence,
    output logic [owbm_pkg::BYTE_W-1:0]   m_read_data,
    output logic                          m_rejected
);
    import owbm_pkg::*;

    typedef enum logic [2:0] {
        PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_REC, PH_SLOT_LOW, PH_HOLD, PH_REC
    } phase_t;

    phase_t                 phase_reg, phase_next;
    logic [REQ_W-1:0]       kind_reg, kind_next;
    logic [CFG_W-1:0]       timer_reg, timer_next;
    logic [BIT_CNT_W-1:0]   bit_cnt_reg, bit_cnt_next;
    logic [BYTE_W-1:0]      shift_reg, shift_next;
    logic                   presence_reg, presence_next;

    logic                   m_valid_reg;
    logic                   drive_reg, drive_next;
    logic                   busy_reg;
    logic                   done_reg, done_next;
    logic [BYTE_W-1:0]      rdata_reg, rdata_next;
    logic                   rej_reg, rej_next;

    logic                   accept;
    logic                   is_cmd;
    logic                   is_write;
    logic                   is_read;

    // a new beat enters whenever the result register is free or draining
    assign s_ready = !m_valid_reg || m_ready;
    assign accept  = s_valid && s_ready;
    assign is_cmd  = (s_req_type == REQ_RESET) || (s_req_type == REQ_WBIT) ||
                     (s_req_type == REQ_WBYTE) || (s_req_type == REQ_RBIT) ||
                     (s_req_type == REQ_RBYTE);
    assign is_write = (kind_next == REQ_WBIT) || (kind_next == REQ_WBYTE);
    assign is_read  = (kind_next == REQ_RBIT) || (kind_next == REQ_RBYTE);

    // command start: latch the kind and clear the bit count; flag a command that arrives while busy
    always_comb begin
        kind_next    = kind_reg;
        bit_cnt_next = bit_cnt_reg;
        rej_next     = 1'b0;
        if (phase_reg != PH_IDLE) begin
            rej_next = is_cmd;
        end else if (is_cmd) begin
            kind_next    = s_req_type;
            bit_cnt_next = '0;
        end
        // slot end advances the bit count
        if (phase_reg != PH_IDLE || is_cmd) begin
            if (phase_reg == PH_REC && timer_reg == CFG_W'(1)) begin
                bit_cnt_next = bit_cnt_reg + BIT_CNT_W'(1);
            end
        end
    end

    // one tick of the slot timing
    always_comb begin
        phase_t           ph;
        logic [CFG_W-1:0] tmr;
        logic [BYTE_W-1:0] sd;
        ph            = phase_reg;
        tmr           = timer_reg;
        sd            = shift_reg;
        presence_next = presence_reg;
        drive_next    = 1'b0;
        done_next     = 1'b0;

        if (phase_reg == PH_IDLE && is_cmd) begin
            sd = ((s_req_type == REQ_WBIT) || (s_req_type == REQ_WBYTE)) ?
                 s_write_data : '0;
            if (s_req_type == REQ_RESET) begin
                ph  = PH_RST_LOW;
                tmr = dur(cfg.reset_low);
            end else begin
                ph  = PH_SLOT_LOW;
                tmr = dur(cfg.slot_low);
            end
        end

        if (ph != PH_IDLE) begin
            // line drive for this tick
            if (ph == PH_RST_LOW || ph == PH_SLOT_LOW) begin
                drive_next = 1'b1;
            end else if (ph == PH_HOLD && is_write) begin
                drive_next = !sd[0];
            end
            tmr = tmr - CFG_W'(1);
            if (tmr == '0) begin
                case (ph)
                    PH_RST_LOW: begin
                        ph  = PH_RST_WAIT;
                        tmr = dur(cfg.presence_smp);
                    end
                    PH_RST_WAIT: begin
                        presence_next = !s_line_level;
                        ph  = PH_RST_REC;
                        tmr = dur(cfg.reset_rec);
                    end
                    PH_RST_REC: begin
                        ph        = PH_IDLE;
                        done_next = 1'b1;
                    end
                    PH_SLOT_LOW: begin
                        ph  = PH_HOLD;
                        tmr = is_write ? dur(cfg.write_hold) : dur(cfg.read_smp);
                    end
                    PH_HOLD: begin
                        // sample point of a read slot
                        if (kind_next == REQ_RBIT) begin
                            sd = {{(BYTE_W-1){1'b0}}, s_line_level};
                        end else if (kind_next == REQ_RBYTE) begin
                            sd = {s_line_level, sd[BYTE_W-1:1]};
                        end
                        ph  = PH_REC;
                        tmr = is_write ? dur(cfg.write_rec) : dur(cfg.read_rec);
                    end
                    PH_REC: begin
                        if (kind_next == REQ_WBYTE) begin
                            sd = {1'b0, sd[BYTE_W-1:1]};
                        end
                        if (kind_next == REQ_WBIT || kind_next == REQ_RBIT ||
                            bit_cnt_next >= BITS_PER_BYTE) begin
                            ph        = PH_IDLE;
                            done_next = 1'b1;
                        end else begin
                            ph  = PH_SLOT_LOW;
                            tmr = dur(cfg.slot_low);
                        end
                    end
                    default: begin
                        ph = PH_IDLE;
                    end
                endcase
                if (ph == PH_IDLE) begin
                    tmr = '0;
                end
            end
        end

        phase_next = ph;
        timer_next = tmr;
        shift_next = sd;
        rdata_next = (done_next && is_read) ? sd : '0;
    end

    // state and result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg    <= PH_IDLE;
            kind_reg     <= '0;
            timer_reg    <= '0;
            bit_cnt_reg  <= '0;
            shift_reg    <= '0;
            presence_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (accept) begin
                phase_reg    <= phase_next;
                kind_reg     <= kind_next;
                timer_reg    <= timer_next;
                bit_cnt_reg  <= bit_cnt_next;
                shift_reg    <= shift_next;
                presence_reg <= presence_next;
                m_valid_reg  <= 1'b1;
                drive_reg    <= drive_next;
                busy_reg     <= (phase_next != PH_IDLE);
                done_reg     <= done_next;
                rdata_reg    <= rdata_next;
                rej_reg      <= rej_next;
            end else if (m_ready) begin
                m_valid_reg  <= 1'b0;
            end
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_drive_low = drive_reg;
    assign m_busy_res  = busy_reg;
    assign m_done_res  = done_reg;
    assign m_presence  = presence_reg;
    assign m_read_data = rdata_reg;
    assign m_rejected  = rej_reg;

    // a finishing beat never also reports busy
    a_done_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && done_reg |-> !busy_reg)
        else $error("done and busy reported together");

    // read data only shows on a done beat
    a_rdata_on_done: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && (rdata_reg != '0) |-> done_reg)
        else $error("read data outside a done beat");

    // idle sequencer keeps its timer cleared
    a_idle_timer: assert property (@(posedge aclk) disable iff (!aresetn)
        phase_reg == PH_IDLE |-> timer_reg == '0)
        else $error("timer running while idle");

    // bit count never passes a full byte
    a_bit_cnt: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_cnt_reg <= BITS_PER_BYTE)
        else $error("bit count overran a byte");

    // the bus is only pulled low while a command runs
    a_drive_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && drive_reg |-> busy_reg || done_reg)
        else $error("bus driven with no command");

endmodule

/* rtl/one_wire_bus_master_top.sv */
// 1-Wire bus master, top level: timing registers and slot sequencer.
// Uses the 1-Wire master blocks owbm_cfg_regs and owbm_core.
//
// Usage: every input beat on s_* is one microsecond tick carrying the
// sampled bus level and, optionally, a command (reset with presence
// detect, write bit/byte, read bit/byte; bytes go LSB first). Every beat
// yields exactly one result beat on m_* with the bus drive for that tick,
// busy, done, presence, read data (non-zero only on the done beat of a
// read) and a flag for a command ignored because one was running.
// The result register makes each result beat appear in the cycle after
// its input beat; one beat is taken every cycle while m_ready is high.
// Slot timing comes from eight 10-bit registers that the user must write
// via cfg_we/cfg_index/cfg_data while idle; the block does not check.
// Reset (aresetn low, synchronous) returns the sequencer to idle, clears
// presence and loads the standard slot timings. When the receiver stalls
// the result beat holds and s_ready drops, so ticks are held off upstream.
module one_wire_bus_master_top (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [owbm_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [owbm_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [owbm_pkg::REQ_W-1:0]    s_req_type,
    input  logic [owbm_pkg::BYTE_W-1:0]   s_write_data,
    input  logic                          s_line_level,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_drive_low,
    output logic                          m_busy_res,
    output logic                          m_done_res,
    output logic                          m_presence,
    output logic [owbm_pkg::BYTE_W-1:0]   m_read_data,
    output logic                          m_rejected
);
    import owbm_pkg::*;

    owbm_cfg_t cfg;

    // timing registers
    owbm_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // slot sequencer and result register
    owbm_core u_core (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_write_data (s_write_data),
        .s_line_level (s_line_level),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_drive_low  (m_drive_low),
        .m_busy_res   (m_busy_res),
        .m_done_res   (m_done_res),
        .m_presence   (m_presence),
        .m_read_data  (m_read_data),
        .m_rejected   (m_rejected)
    );

endmodule

/* test/one_wire_bus_master_top_test.sv */
`timescale 1ns / 1ps
// Self-checking testbench for one_wire_bus_master_top: reset, write and read slots timed per tick.
// A tick-level predictor built on owbm_pkg codes checks every result beat against the RTL.
module one_wire_bus_master_top_test;
    import owbm_pkg::*;

    // sequencer phases of the predictor
    typedef enum logic [2:0] {
        PH_IDLE, PH_RST_LOW, PH_RST_WAIT, PH_RST_REC, PH_SLOT_LOW, PH_HOLD, PH_REC
    } bus_phase_e;

    // one expected result beat
    typedef struct packed {
        logic              drive_low;
        logic              busy_res;
        logic              done_res;
        logic              presence;
        logic [BYTE_W-1:0] read_data;
        logic              rejected;
    } tick_result_t;

    // timing register set, element i is register i
    typedef logic [7:0][CFG_W-1:0] timing_set_t;

    localparam logic [REQ_W-1:0] REQ_SPARE_LO = 3'd6;
    localparam logic [REQ_W-1:0] REQ_SPARE_HI = 3'd7;
    localparam int LINE_LOW     = 0;
    localparam int LINE_HIGH    = 1;
    localparam int LINE_RANDOM  = 2;
    localparam int LONG_STALL   = 300;
    localparam int CYCLE_LIMIT  = 6_000_000;

    // short slot timings so that whole bytes fit in a few dozen ticks
    localparam timing_set_t SHORT_TIMING = {10'd1, 10'd2, 10'd1, 10'd1,
                                            10'd1, 10'd2, 10'd2, 10'd3};

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_W-1:0]      cfg_data;
    logic                  s_valid;
    logic                  s_ready;
    logic [REQ_W-1:0]      s_req_type;
    logic [BYTE_W-1:0]     s_write_data;
    logic                  s_line_level;
    logic                  m_valid;
    logic                  m_ready;
    logic                  m_drive_low;
    logic                  m_busy_res;
    logic                  m_done_res;
    logic                  m_presence;
    logic [BYTE_W-1:0]     m_read_data;
    logic                  m_rejected;

    // predictor state
    timing_set_t           timing;
    bus_phase_e            ph;
    logic [REQ_W-1:0]      cmd_kind;
    logic [CFG_W-1:0]      ph_timer;
    logic [BIT_CNT_W-1:0]  bit_cnt;
    logic [BYTE_W-1:0]     shift_reg;
    logic                  presence_q;

    tick_result_t          expected_ticks[$];
    int                    fail_count = 0;
    int unsigned           cycle_count = 0;
    bit                    calm = 1'b0;
    bit                    long_stall_req = 1'b0;

    one_wire_bus_master_top u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_write_data (s_write_data),
        .s_line_level (s_line_level),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_drive_low  (m_drive_low),
        .m_busy_res   (m_busy_res),
        .m_done_res   (m_done_res),
        .m_presence   (m_presence),
        .m_read_data  (m_read_data),
        .m_rejected   (m_rejected)
    );

    always #10 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // ---------------- predictor ----------------

    function automatic logic writing();
        return cmd_kind == REQ_WBIT || cmd_kind == REQ_WBYTE;
    endfunction

    // a zero register value still lasts one tick
    function automatic void enter_phase(bus_phase_e nxt, logic [CFG_IDX_W-1:0] idx);
        ph = nxt;
        ph_timer = (timing[idx] == '0) ? CFG_W'(1) : timing[idx];
    endfunction

    task automatic predict_tick(input logic [REQ_W-1:0] req, input logic [BYTE_W-1:0] wd,
                                input logic line);
        tick_result_t r;
        logic         is_cmd;
        logic         done;
        r = '0;
        done = 1'b0;
        is_cmd = (req >= REQ_RESET) && (req <= REQ_RBYTE);

        // start on an idle tick, reject while busy
        if (ph != PH_IDLE) begin
            if (is_cmd) r.rejected = 1'b1;
        end else if (is_cmd) begin
            cmd_kind = req;
            bit_cnt = '0;
            shift_reg = (req == REQ_WBIT || req == REQ_WBYTE) ? wd : '0;
            if (req == REQ_RESET) enter_phase(PH_RST_LOW, REG_RESET_LOW);
            else enter_phase(PH_SLOT_LOW, REG_SLOT_LOW);
        end

        if (ph != PH_IDLE) begin
            // line drive for this tick; a one bit releases the line
            if (ph == PH_RST_LOW || ph == PH_SLOT_LOW) r.drive_low = 1'b1;
            else if (ph == PH_HOLD && writing()) r.drive_low = ~shift_reg[0];
            ph_timer = ph_timer - CFG_W'(1);
            if (ph_timer == '0) begin
                // phase transitions
                case (ph)
                    PH_RST_LOW: enter_phase(PH_RST_WAIT, REG_PRESENCE_SMP);
                    PH_RST_WAIT: begin
                        presence_q = ~line;
                        enter_phase(PH_RST_REC, REG_RESET_REC);
                    end
                    PH_RST_REC: begin
                        ph = PH_IDLE;
                        ph_timer = '0;
                        done = 1'b1;
                    end
                    PH_SLOT_LOW: enter_phase(PH_HOLD, writing() ? REG_WRITE_HOLD : REG_READ_SMP);
                    PH_HOLD: begin
                        if (cmd_kind == REQ_RBIT) shift_reg = {7'b0, line};
                        else if (cmd_kind == REQ_RBYTE) shift_reg = {line, shift_reg[7:1]};
                        enter_phase(PH_REC, writing() ? REG_WRITE_REC : REG_READ_REC);
                    end
                    PH_REC: begin
                        if (cmd_kind == REQ_WBYTE) shift_reg = shift_reg >> 1;
                        bit_cnt = bit_cnt + BIT_CNT_W'(1);
                        if (cmd_kind == REQ_WBIT || cmd_kind == REQ_RBIT ||
                            bit_cnt >= BITS_PER_BYTE) begin
                            ph = PH_IDLE;
                            ph_timer = '0;
                            done = 1'b1;
                        end else begin
                            enter_phase(PH_SLOT_LOW, REG_SLOT_LOW);
                        end
                    end
                    default: begin
                        ph = PH_IDLE;
                        ph_timer = '0;
                    end
                endcase
            end
        end

        if (done && (cmd_kind == REQ_RBIT || cmd_kind == REQ_RBYTE)) r.read_data = shift_reg;
        r.busy_res = (ph != PH_IDLE);
        r.done_res = done;
        r.presence = presence_q;
        expected_ticks.push_back(r);
    endtask

    // ---------------- result checking ----------------

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h actual 0x%0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        tick_result_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_ticks.size() == 0) begin
                $error("result beat with no expectation waiting");
                fail_count++;
            end else begin
                want = expected_ticks.pop_front();
                check_field("drive_low", 32'(want.drive_low), 32'(m_drive_low));
                check_field("busy_res", 32'(want.busy_res), 32'(m_busy_res));
                check_field("done_res", 32'(want.done_res), 32'(m_done_res));
                check_field("presence", 32'(want.presence), 32'(m_presence));
                check_field("read_data", 32'(want.read_data), 32'(m_read_data));
                check_field("rejected", 32'(want.rejected), 32'(m_rejected));
            end
        end
    end

    // ---------------- result ready ----------------

    // random stalls, a long hold-off on request, none in the calm part
    initial begin : result_sink
        int n;
        m_ready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if (long_stall_req) begin
                m_ready <= 1'b0;
                repeat (LONG_STALL) @(negedge aclk);
                long_stall_req = 1'b0;
                m_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                n = $urandom_range(1, 13);
                m_ready <= 1'b0;
                repeat (n) @(negedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ---------------- stimulus ----------------

    // offer one tick beat, sometimes after a random gap (never in the calm part)
    task automatic send_tick(input logic [REQ_W-1:0] req, input logic [BYTE_W-1:0] wd,
                             input logic line);
        int gap;
        @(negedge aclk);
        if (!calm && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 13);
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= req;
        s_write_data <= wd;
        s_line_level <= line;
        predict_tick(req, wd, line);
        do @(posedge aclk); while (!s_ready);
    endtask

    // finish the running command, pause the sender and let every result drain
    task automatic settle_idle();
        while (ph != PH_IDLE)
            send_tick(REQ_TICK, BYTE_W'($urandom), 1'($urandom_range(0, 1)));
        @(negedge aclk);
        s_valid <= 1'b0;
        while (expected_ticks.size() != 0) @(posedge aclk);
        repeat (2) @(negedge aclk);
    endtask

    task automatic apply_timing(input timing_set_t t);
        settle_idle();
        for (int i = 0; i < 8; i++) begin
            @(negedge aclk);
            cfg_we    <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= t[i];
            timing[i] = t[i];
        end
        @(negedge aclk);
        cfg_we <= 1'b0;
    endtask

    function automatic timing_set_t pick_timing(int unsigned top);
        timing_set_t t;
        for (int i = 0; i < 8; i++) begin
            case ($urandom_range(0, 5))
                0: t[i] = '0;
                1: t[i] = CFG_W'(1);
                default: t[i] = CFG_W'($urandom_range(2, top));
            endcase
        end
        return t;
    endfunction

    // one command followed by ticks until it completes
    task automatic run_command(input logic [REQ_W-1:0] req, input logic [BYTE_W-1:0] wd,
                               input int mode);
        logic [REQ_W-1:0] r;
        logic             lvl;
        r = req;
        do begin
            lvl = (mode == LINE_RANDOM) ? 1'($urandom_range(0, 1)) : (mode == LINE_HIGH);
            send_tick(r, wd, lvl);
            r = REQ_TICK;
        end while (ph != PH_IDLE);
    endtask

    // well-formed commands on idle ticks, noise and rejected commands while busy
    task automatic drive_traffic(input int n_cmds);
        int               started;
        logic [REQ_W-1:0] req;
        started = 0;
        while (started < n_cmds) begin
            if (ph == PH_IDLE) begin
                case ($urandom_range(0, 9))
                    0: req = REQ_TICK;
                    1: req = REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
                    default: begin
                        req = REQ_W'($urandom_range(REQ_RESET, REQ_RBYTE));
                        started++;
                    end
                endcase
            end else begin
                case ($urandom_range(0, 19))
                    0: req = REQ_W'($urandom_range(REQ_RESET, REQ_RBYTE));
                    1: req = REQ_W'($urandom_range(REQ_SPARE_LO, REQ_SPARE_HI));
                    default: req = REQ_TICK;
                endcase
            end
            send_tick(req, BYTE_W'($urandom), 1'($urandom_range(0, 1)));
        end
    endtask

    // ---------------- tests ----------------

    // one read slot on the timings loaded by reset
    task automatic test_default_timing();
        run_command(REQ_RBIT, 8'h00, LINE_LOW);
    endtask

    task automatic test_reset_presence();
        apply_timing(SHORT_TIMING);
        run_command(REQ_RESET, 8'h00, LINE_LOW);
        run_command(REQ_RESET, 8'hff, LINE_HIGH);
    endtask

    task automatic test_write_slots();
        run_command(REQ_WBIT, 8'h00, LINE_RANDOM);
        run_command(REQ_WBIT, 8'hff, LINE_RANDOM);
        run_command(REQ_WBYTE, 8'hff, LINE_RANDOM);
        run_command(REQ_WBYTE, 8'h5a, LINE_RANDOM);
    endtask

    task automatic test_read_slots();
        run_command(REQ_RBIT, 8'h00, LINE_LOW);
        run_command(REQ_RBIT, 8'hff, LINE_HIGH);
        run_command(REQ_RBYTE, 8'h00, LINE_RANDOM);
    endtask

    // commands while busy, also on the done tick, and unused request codes
    task automatic test_busy_and_unknown();
        send_tick(REQ_SPARE_LO, 8'hff, 1'b1);
        send_tick(REQ_SPARE_HI, 8'h00, 1'b0);
        send_tick(REQ_WBIT, 8'h01, 1'b1);
        while (ph != PH_IDLE)
            send_tick(REQ_W'($urandom_range(REQ_RESET, REQ_RBYTE)), BYTE_W'($urandom),
                      1'($urandom_range(0, 1)));
        send_tick(REQ_RBYTE, 8'h00, 1'b0);
        while (ph != PH_IDLE)
            send_tick(REQ_W'($urandom_range(REQ_TICK, REQ_SPARE_HI)), BYTE_W'($urandom),
                      1'($urandom_range(0, 1)));
    endtask

    // zero-valued registers act as one tick
    task automatic test_timing_extremes();
        apply_timing('0);
        run_command(REQ_RESET, 8'h00, LINE_LOW);
        run_command(REQ_WBYTE, 8'hc3, LINE_RANDOM);
        run_command(REQ_RBYTE, 8'h00, LINE_RANDOM);
        run_command(REQ_WBIT, 8'h00, LINE_RANDOM);
        run_command(REQ_RBIT, 8'h00, LINE_HIGH);
    endtask

    // receiver holds off long while the sender keeps offering ticks
    task automatic test_backpressure();
        apply_timing(pick_timing(2));
        long_stall_req = 1'b1;
        drive_traffic(3);
        settle_idle();
    endtask

    task automatic test_random_traffic();
        apply_timing(pick_timing(3));
        drive_traffic(3);
        // last part without idling
        calm = 1'b1;
        apply_timing(pick_timing(2));
        drive_traffic(3);
    endtask

    // ---------------- sequence ----------------

    initial begin
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        s_valid      = 1'b0;
        s_req_type   = REQ_TICK;
        s_write_data = '0;
        s_line_level = 1'b1;
        timing       = {DEF_READ_REC, DEF_READ_SMP, DEF_WRITE_REC, DEF_WRITE_HOLD,
                        DEF_SLOT_LOW, DEF_RESET_REC, DEF_PRESENCE_SMP, DEF_RESET_LOW};
        ph           = PH_IDLE;
        cmd_kind     = REQ_TICK;
        ph_timer     = '0;
        bit_cnt      = '0;
        shift_reg    = '0;
        presence_q   = 1'b0;
        repeat (6) @(negedge aclk);
        aresetn <= 1'b1;

        test_default_timing();
        test_reset_presence();
        test_write_slots();
        test_read_slots();
        test_busy_and_unknown();
        test_timing_extremes();
        test_backpressure();
        test_random_traffic();

        settle_idle();
        repeat (8) @(posedge aclk);
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
